// ===== rtl/core/pou_pkg.sv =====
package pou_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EXP_INT_COUNT = 18;
  localparam int QW = 21;                 // width of an unsaturated exponent argument
  localparam int FW = FRAC_BITS + 1;      // fitness and draw width
  localparam int DIV_STAGES = QW;

  localparam logic [7:0] REG_COL_RATE = 8'd0;
  localparam logic [7:0] REG_EXT_RATE = 8'd1;
  localparam logic [7:0] REG_REG_EN   = 8'd2;

  typedef enum logic [2:0] {
    EV_EMPTY     = 3'd0,
    EV_COLONIZED = 3'd1,
    EV_SURVIVED  = 3'd2,
    EV_EXTINCT   = 3'd3,
    EV_CLEARED   = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    MODE_FIXED = 2'd0,
    MODE_COL   = 2'd1,
    MODE_EXT   = 2'd2
  } mode_t;

  // One item in flight through the divider section
  typedef struct packed {
    mode_t           mode;
    event_t          ev;
    logic [FW-1:0]   draw;
    logic            sat;
    logic [QW-1:0]   xq;
    logic [FW-1:0]   rem;
    logic [FW-1:0]   fs;
  } stage_t;

  // Configuration as seen by the pipeline
  typedef struct packed {
    logic [31:0] col_rate;
    logic [31:0] ext_rate;
    logic        reg_en;
  } cfg_t;

  // exp(-n), Q24
  function automatic logic [24:0] exp_int(input logic [4:0] n);
    logic [24:0] r;
    case (n)
      5'd0:  r = 25'd16777216;
      5'd1:  r = 25'd6171993;
      5'd2:  r = 25'd2270549;
      5'd3:  r = 25'd835288;
      5'd4:  r = 25'd307285;
      5'd5:  r = 25'd113044;
      5'd6:  r = 25'd41587;
      5'd7:  r = 25'd15299;
      5'd8:  r = 25'd5628;
      5'd9:  r = 25'd2070;
      5'd10: r = 25'd762;
      5'd11: r = 25'd280;
      5'd12: r = 25'd103;
      5'd13: r = 25'd38;
      5'd14: r = 25'd14;
      5'd15: r = 25'd5;
      5'd16: r = 25'd2;
      5'd17: r = 25'd1;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

  // exp(-j/16), Q24
  function automatic logic [24:0] exp_frac(input logic [4:0] j);
    logic [24:0] r;
    case (j)
      5'd0:  r = 25'd16777216;
      5'd1:  r = 25'd15760736;
      5'd2:  r = 25'd14805841;
      5'd3:  r = 25'd13908801;
      5'd4:  r = 25'd13066109;
      5'd5:  r = 25'd12274473;
      5'd6:  r = 25'd11530801;
      5'd7:  r = 25'd10832185;
      5'd8:  r = 25'd10175896;
      5'd9:  r = 25'd9559370;
      5'd10: r = 25'd8980197;
      5'd11: r = 25'd8436114;
      5'd12: r = 25'd7924996;
      5'd13: r = 25'd7444844;
      5'd14: r = 25'd6993784;
      5'd15: r = 25'd6570052;
      5'd16: r = 25'd6171993;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/pou_front.sv =====
module pou_front import pou_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  cfg_t                cfg,
  input  logic                in_vld,
  input  logic                occupied,
  input  logic [FW-1:0]       fitness,
  input  logic signed [31:0]  connectivity,
  input  logic [FW-1:0]       uniform_draw,
  input  logic signed [31:0]  regional_factor,
  output logic                out_vld,
  output stage_t              out_item
);

  logic          v1;
  mode_t         mode1;
  event_t        ev1;
  logic [FW-1:0] draw1;
  logic [62:0]   cprod;
  logic [FW-1:0] fs1;

  mode_t         mode_d;
  event_t        ev_d;
  logic          scaled;
  logic [30:0]   s_pos;
  logic [32:0]   fsmul;
  logic [FW-1:0] fs_d;

  stage_t        item_d;
  logic [26:0]   rem0;

  // Classify the patch and scale fitness
  always_comb begin
    scaled = cfg.reg_en && (regional_factor < 32'sd65536);
    s_pos  = connectivity[31] ? 31'd0 : connectivity[30:0];
    fsmul  = fitness * regional_factor[15:0];
    fs_d   = scaled ? fsmul[32:16] : fitness;
    mode_d = MODE_EXT;
    ev_d   = EV_SURVIVED;
    if (fitness == '0) begin
      mode_d = MODE_FIXED;
      ev_d   = EV_CLEARED;
    end else if (!occupied) begin
      mode_d = MODE_COL;
      ev_d   = EV_EMPTY;
    end else if (scaled && regional_factor <= 32'sd0) begin
      mode_d = MODE_FIXED;
      ev_d   = EV_EXTINCT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1 <= mode_d;
      ev1   <= ev_d;
      draw1 <= uniform_draw;
      cprod <= cfg.col_rate * s_pos;
      fs1   <= fs_d;
    end
  end

  // Form exponent argument or set up the divider
  always_comb begin
    rem0        = cfg.ext_rate[31:5];
    item_d.mode = mode1;
    item_d.ev   = ev1;
    item_d.draw = draw1;
    item_d.fs   = fs1;
    item_d.sat  = 1'b0;
    item_d.xq   = '0;
    item_d.rem  = '0;
    case (mode1)
      MODE_COL: begin
        item_d.sat = cprod[62:32] >= 31'(EXP_INT_COUNT);
        item_d.xq  = cprod[36:16];
      end
      MODE_EXT: begin
        if (fs1 == '0) begin
          item_d.mode = MODE_FIXED;
          item_d.ev   = EV_EXTINCT;
        end
        item_d.sat = rem0 >= {10'd0, fs1};
        item_d.rem = rem0[FW-1:0];
        item_d.xq  = {cfg.ext_rate[4:0], 16'd0};
      end
      default: begin
        item_d.xq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= item_d;
    end
  end

endmodule

// ===== rtl/core/pou_div.sv =====
module pou_div import pou_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_vld,
  input  stage_t in_item,
  output logic   out_vld,
  output stage_t out_item
);

  logic   vld [DIV_STAGES];
  stage_t st  [DIV_STAGES];
  stage_t nxt [DIV_STAGES];

  // One restoring quotient bit per stage
  always_comb begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      stage_t src;
      logic [FW:0] r2;
      src = (i == 0) ? in_item : st[(i == 0) ? 0 : i - 1];
      r2  = {src.rem, src.xq[QW-1]};
      nxt[i] = src;
      if (src.mode == MODE_EXT) begin
        if (r2 >= {1'b0, src.fs}) begin
          nxt[i].rem = FW'(r2 - {1'b0, src.fs});
          nxt[i].xq  = {src.xq[QW-2:0], 1'b1};
        end else begin
          nxt[i].rem = r2[FW-1:0];
          nxt[i].xq  = {src.xq[QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
      for (int i = 1; i < DIV_STAGES; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DIV_STAGES; i++) st[i] <= nxt[i];
    end
  end

  assign out_vld  = vld[DIV_STAGES-1];
  assign out_item = st[DIV_STAGES-1];

endmodule

// ===== rtl/core/pou_exp.sv =====
module pou_exp import pou_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_vld,
  input  stage_t in_item,
  output logic   out_vld,
  output logic   new_occupied,
  output event_t event_res
);

  logic          va, vb, vc;
  mode_t         ma, mb, mc;
  event_t        ea, eb, ec;
  logic [FW-1:0] da, db, dc;
  logic          sa, sb, sc;
  logic [4:0]    na, nb;
  logic [24:0]   ta, vb_val;
  logic [31:0]   pa;
  logic [49:0]   yc;

  logic [4:0]    n_d;
  logic [24:0]   tj, tj1;
  logic [19:0]   diff;
  logic [FW-1:0] expv;
  logic [FW:0]   prob;
  logic          hit;
  event_t        ev_d;

  always_comb begin
    n_d  = in_item.xq[QW-1:16];
    tj   = exp_frac({1'b0, in_item.xq[15:12]});
    tj1  = exp_frac(5'({1'b0, in_item.xq[15:12]} + 5'd1));
    diff = 20'(tj - tj1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      va <= in_vld;
      vb <= va;
      vc <= vb;
      out_vld <= vc;
    end
  end

  // Interpolate segment, then scale by the integer part
  always_ff @(posedge clk) begin
    if (adv) begin
      ma <= in_item.mode;
      ea <= in_item.ev;
      da <= in_item.draw;
      sa <= in_item.sat || (n_d >= 5'(EXP_INT_COUNT));
      na <= n_d;
      ta <= tj;
      pa <= diff * in_item.xq[11:0];

      mb <= ma;
      eb <= ea;
      db <= da;
      sb <= sa;
      nb <= na;
      vb_val <= ta - 25'(pa[31:12]);

      mc <= mb;
      ec <= eb;
      dc <= db;
      sc <= sb;
      yc <= exp_int(nb) * vb_val;

      event_res    <= ev_d;
      new_occupied <= (ev_d == EV_COLONIZED) || (ev_d == EV_SURVIVED);
    end
  end

  // Compare the draw against 1 - exp(-x)
  always_comb begin
    expv = sc ? '0 : yc[48:32];
    prob = (FW+1)'(1 << FRAC_BITS) - {1'b0, expv};
    hit  = {1'b0, dc} < prob;
    case (mc)
      MODE_COL: ev_d = hit ? EV_COLONIZED : EV_EMPTY;
      MODE_EXT: ev_d = hit ? EV_EXTINCT : EV_SURVIVED;
      default:  ev_d = ec;
    endcase
  end

endmodule

// ===== rtl/core/patch_occupancy_update.sv =====
// Patch occupancy update, one patch per item.
// Input channel: in_valid/in_ready with occupied, fitness, connectivity,
// uniform_draw and regional_factor. Output channel: out_valid/out_ready with
// new_occupied and event_res (0 stayed empty, 1 colonized, 2 survived,
// 3 went extinct, 4 cleared for zero fitness).
// Configuration: cfg_valid/cfg_ready with cfg_index (0 colonization rate,
// 1 extinction rate, 2 regional enable) and cfg_data; cfg_ready is always
// high, other indexes are dropped. Write only while the pipeline is empty.
// Throughput: one item per cycle unless the receiver stalls. Each item passes
// through 27 register stages: two front stages, 21 stages of the restoring
// divider (one quotient bit each) and four stages of exp interpolation and
// compare.
// When the receiver stalls, the whole pipeline holds and in_ready drops
// only while a result waits at the output; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults
// (rates 1.0, regional scaling off).
module patch_occupancy_update import pou_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               occupied,
  input  logic [16:0]        fitness,
  input  logic signed [31:0] connectivity,
  input  logic [16:0]        uniform_draw,
  input  logic signed [31:0] regional_factor,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               new_occupied,
  output logic [2:0]         event_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t   cfg;
  logic   adv;
  logic   f_vld, d_vld;
  stage_t f_item, d_item;
  event_t ev;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign event_res = ev;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.col_rate <= 32'd65536;
      cfg.ext_rate <= 32'd65536;
      cfg.reg_en   <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_COL_RATE) cfg.col_rate <= cfg_data;
      if (cfg_index == REG_EXT_RATE) cfg.ext_rate <= cfg_data;
      if (cfg_index == REG_REG_EN)   cfg.reg_en   <= cfg_data[0];
    end
  end

  pou_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .cfg(cfg),
    .in_vld(in_valid && in_ready),
    .occupied(occupied), .fitness(fitness), .connectivity(connectivity),
    .uniform_draw(uniform_draw), .regional_factor(regional_factor),
    .out_vld(f_vld), .out_item(f_item)
  );

  pou_div u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(f_vld), .in_item(f_item),
    .out_vld(d_vld), .out_item(d_item)
  );

  pou_exp u_exp (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(d_vld), .in_item(d_item),
    .out_vld(out_valid), .new_occupied(new_occupied), .event_res(ev)
  );

endmodule
